[sv/lcm_of_three_unit_macros.svh]
// Assertion macros for the lcm_of_three_unit sources.
`ifndef LCM_OF_THREE_UNIT_MACROS_SVH
`define LCM_OF_THREE_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Check that pre implies post in the same cycle.
`define LCM3_ASSERT_IMP(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("lcm3 check failed");

// Check that pre implies post in the following cycle.
`define LCM3_ASSERT_NXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("lcm3 check failed");

`else

`define LCM3_ASSERT_IMP(lbl, clk, rst_n, pre, post)
`define LCM3_ASSERT_NXT(lbl, clk, rst_n, pre, post)

`endif

`endif

[sv/lcm3_pkg.sv]
`timescale 1ns / 1ps
package lcm3_pkg;

    // Fixed payload widths
    localparam int PERIOD_W   = 21;
    localparam int MULTIPLE_W = 63;

    typedef struct packed {
        logic [PERIOD_W-1:0] period_a;
        logic [PERIOD_W-1:0] period_b;
        logic [PERIOD_W-1:0] period_c;
    } t_in_item;

    typedef struct packed {
        logic [MULTIPLE_W-1:0] multiple;
        logic                  zero_divisor;
    } t_out_item;

    // Control FSM
    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    // Micro-operations
    typedef enum logic [4:0] {
        OP_NONE,
        OP_MUL_AB,
        OP_MUL_AC,
        OP_MUL_BC,
        OP_MUL_FULL,
        OP_SAVE_AB,
        OP_SAVE_AC,
        OP_SAVE_BC,
        OP_SAVE_FULL,
        OP_LOAD_AB,
        OP_LOAD_AC,
        OP_LOAD_BC,
        OP_MOD,
        OP_SAVE_MOD,
        OP_DIV,
        OP_FIN_DIV,
        OP_FIN_ZERO
    } t_op;

    // Jump conditions
    typedef enum logic [1:0] {
        C_NEXT,
        C_ALWAYS,
        C_Y_ZERO,
        C_X_ZERO
    } t_cond;

    localparam int UPC_W    = 5;
    localparam int PROG_LEN = 24;

    typedef struct packed {
        t_op              op;
        t_cond            cond;
        logic [UPC_W-1:0] target;
    } t_uword;

    // Microprogram: products, three Euclid loops, final division
    function automatic t_uword uprog(input logic [UPC_W-1:0] pc);
        t_uword w;
        w = '{op: OP_NONE, cond: C_NEXT, target: '0};
        case (pc)
            5'd0:  w = '{op: OP_MUL_AB,   cond: C_NEXT,   target: 5'd0};
            5'd1:  w = '{op: OP_SAVE_AB,  cond: C_NEXT,   target: 5'd0};
            5'd2:  w = '{op: OP_MUL_AC,   cond: C_NEXT,   target: 5'd0};
            5'd3:  w = '{op: OP_SAVE_AC,  cond: C_NEXT,   target: 5'd0};
            5'd4:  w = '{op: OP_MUL_BC,   cond: C_NEXT,   target: 5'd0};
            5'd5:  w = '{op: OP_SAVE_BC,  cond: C_NEXT,   target: 5'd0};
            5'd6:  w = '{op: OP_MUL_FULL, cond: C_NEXT,   target: 5'd0};
            5'd7:  w = '{op: OP_SAVE_FULL, cond: C_NEXT,  target: 5'd0};
            5'd8:  w = '{op: OP_LOAD_AB,  cond: C_NEXT,   target: 5'd0};
            5'd9:  w = '{op: OP_NONE,     cond: C_Y_ZERO, target: 5'd12};
            5'd10: w = '{op: OP_MOD,      cond: C_NEXT,   target: 5'd0};
            5'd11: w = '{op: OP_SAVE_MOD, cond: C_ALWAYS, target: 5'd9};
            5'd12: w = '{op: OP_LOAD_AC,  cond: C_NEXT,   target: 5'd0};
            5'd13: w = '{op: OP_NONE,     cond: C_Y_ZERO, target: 5'd16};
            5'd14: w = '{op: OP_MOD,      cond: C_NEXT,   target: 5'd0};
            5'd15: w = '{op: OP_SAVE_MOD, cond: C_ALWAYS, target: 5'd13};
            5'd16: w = '{op: OP_LOAD_BC,  cond: C_NEXT,   target: 5'd0};
            5'd17: w = '{op: OP_NONE,     cond: C_Y_ZERO, target: 5'd20};
            5'd18: w = '{op: OP_MOD,      cond: C_NEXT,   target: 5'd0};
            5'd19: w = '{op: OP_SAVE_MOD, cond: C_ALWAYS, target: 5'd17};
            5'd20: w = '{op: OP_NONE,     cond: C_X_ZERO, target: 5'd23};
            5'd21: w = '{op: OP_DIV,      cond: C_NEXT,   target: 5'd0};
            5'd22: w = '{op: OP_FIN_DIV,  cond: C_NEXT,   target: 5'd0};
            5'd23: w = '{op: OP_FIN_ZERO, cond: C_NEXT,   target: 5'd0};
            default: w = '{op: OP_NONE,   cond: C_ALWAYS, target: 5'd0};
        endcase
        return w;
    endfunction

endpackage

[sv/lcm_of_three_unit.sv]
`timescale 1ns / 1ps
// Channel   Valid         Ready         Data           Beat
// input     i_in_valid    o_in_ready    i_in_data      three periods
// output    o_out_valid   i_out_ready   o_out_data     multiple, zero_divisor
//
// One item at a time; the next input beat is taken once the previous result is
// in the output register. Each item runs the shift-add products, three Euclid
// remainder loops and the final restoring division, plus sequencer steps.
// A single shift-add multiplier serves all four products, and the divider makes
// one quotient bit per cycle.
// Reset is synchronous, active low; it idles the sequencer and empties the output.
// A stalled output holds the finishing step until the register frees up.
`include "lcm_of_three_unit_macros.svh"

module lcm_of_three_unit #(
    parameter int PERIOD_BITS = 21
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  lcm3_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output lcm3_pkg::t_out_item o_out_data
);
    import lcm3_pkg::*;

    localparam int W2     = 2 * PERIOD_BITS;
    localparam int W3     = 3 * PERIOD_BITS;
    localparam int DCNT_W = $clog2(W3 + 1);

    // Sequencer
    t_state           r_state, n_state;
    logic [UPC_W-1:0] r_pc, n_pc;
    t_uword           w_uw;
    logic             w_accept, w_exec, w_fin, w_jump, w_run;

    // Operands and products
    logic [PERIOD_BITS-1:0] r_a, r_b, r_c;
    logic [W2-1:0]          r_ab, r_ac, r_bc;
    logic [W3-1:0]          r_full;
    logic [W2-1:0]          r_x, r_y;

    // Shift-add multiplier
    logic [W3-1:0]          r_mcand, r_acc;
    logic [PERIOD_BITS-1:0] r_mplier;
    logic                   w_mul_busy, w_mul_start;
    logic [W3-1:0]          w_mcand_ld;
    logic [PERIOD_BITS-1:0] w_mplier_ld;

    // Restoring divider
    logic [W3-1:0]     r_dvd;
    logic [W2-1:0]     r_rem, r_dvs;
    logic [DCNT_W-1:0] r_dcnt;
    logic              w_div_busy, w_ge;
    logic [W2:0]       w_trial, w_diff;

    // Output register
    logic      r_o_valid;
    t_out_item r_out;

    assign w_uw       = uprog(r_pc);
    assign w_mul_busy = (r_mplier != '0);
    assign w_div_busy = (r_dcnt != '0);
    assign w_fin      = (w_uw.op == OP_FIN_DIV) || (w_uw.op == OP_FIN_ZERO);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_exec     = w_run && !w_mul_busy && !w_div_busy &&
                        (!w_fin || !r_o_valid || i_out_ready);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_RUN;
            end
            ST_RUN: begin
                if (w_exec && w_fin) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // FSM outputs
    always_comb begin
        o_in_ready = 1'b0;
        w_run      = 1'b0;
        case (r_state)
            ST_IDLE: o_in_ready = 1'b1;
            ST_RUN:  w_run      = 1'b1;
            default: o_in_ready = 1'b0;
        endcase
    end

    // Evaluate the jump condition
    always_comb begin
        case (w_uw.cond)
            C_NEXT:   w_jump = 1'b0;
            C_ALWAYS: w_jump = 1'b1;
            C_Y_ZERO: w_jump = (r_y == '0);
            C_X_ZERO: w_jump = (r_x == '0);
            default:  w_jump = 1'b0;
        endcase
    end

    // Advance the step counter
    always_comb begin
        n_pc = r_pc;
        if (w_accept) begin
            n_pc = '0;
        end else if (w_exec) begin
            n_pc = w_jump ? w_uw.target : r_pc + UPC_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pc    <= '0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
        end
    end

    // Capture masked periods on an input beat
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_a <= i_in_data.period_a[PERIOD_BITS-1:0];
            r_b <= i_in_data.period_b[PERIOD_BITS-1:0];
            r_c <= i_in_data.period_c[PERIOD_BITS-1:0];
        end
    end

    // Select multiplier operands
    always_comb begin
        w_mul_start = 1'b0;
        w_mcand_ld  = '0;
        w_mplier_ld = '0;
        if (w_exec) begin
            case (w_uw.op)
                OP_MUL_AB: begin
                    w_mul_start = 1'b1;
                    w_mcand_ld  = W3'(r_a);
                    w_mplier_ld = r_b;
                end
                OP_MUL_AC: begin
                    w_mul_start = 1'b1;
                    w_mcand_ld  = W3'(r_a);
                    w_mplier_ld = r_c;
                end
                OP_MUL_BC: begin
                    w_mul_start = 1'b1;
                    w_mcand_ld  = W3'(r_b);
                    w_mplier_ld = r_c;
                end
                OP_MUL_FULL: begin
                    w_mul_start = 1'b1;
                    w_mcand_ld  = W3'(r_ab);
                    w_mplier_ld = r_c;
                end
                default: w_mul_start = 1'b0;
            endcase
        end
    end

    // Shift-add multiplier: one multiplier bit per cycle, done when it runs out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mplier <= '0;
        end else if (w_mul_start) begin
            r_mplier <= w_mplier_ld;
        end else if (w_mul_busy) begin
            r_mplier <= r_mplier >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mul_start) begin
            r_mcand <= w_mcand_ld;
            r_acc   <= '0;
        end else if (w_mul_busy) begin
            r_mcand <= r_mcand << 1;
            if (r_mplier[0]) r_acc <= r_acc + r_mcand;
        end
    end

    // Restoring divider: one quotient bit per cycle
    assign w_trial = {r_rem, r_dvd[W3-1]};
    assign w_ge    = (w_trial >= {1'b0, r_dvs});
    assign w_diff  = w_trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dcnt <= '0;
        end else if (w_exec && w_uw.op == OP_MOD) begin
            r_dcnt <= DCNT_W'(W2);
        end else if (w_exec && w_uw.op == OP_DIV) begin
            r_dcnt <= DCNT_W'(W3);
        end else if (w_div_busy) begin
            r_dcnt <= r_dcnt - DCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_exec && w_uw.op == OP_MOD) begin
            r_dvd <= {r_x, {PERIOD_BITS{1'b0}}};
            r_dvs <= r_y;
            r_rem <= '0;
        end else if (w_exec && w_uw.op == OP_DIV) begin
            r_dvd <= r_full;
            r_dvs <= r_x;
            r_rem <= '0;
        end else if (w_div_busy) begin
            r_dvd <= {r_dvd[W3-2:0], w_ge};
            r_rem <= w_ge ? w_diff[W2-1:0] : w_trial[W2-1:0];
        end
    end

    // Store products and Euclid operands
    always_ff @(posedge i_clk) begin
        if (w_exec) begin
            case (w_uw.op)
                OP_SAVE_AB:   r_ab   <= r_acc[W2-1:0];
                OP_SAVE_AC:   r_ac   <= r_acc[W2-1:0];
                OP_SAVE_BC:   r_bc   <= r_acc[W2-1:0];
                OP_SAVE_FULL: r_full <= r_acc;
                OP_LOAD_AB: begin
                    r_x <= '0;
                    r_y <= r_ab;
                end
                OP_LOAD_AC:   r_y <= r_ac;
                OP_LOAD_BC:   r_y <= r_bc;
                OP_SAVE_MOD: begin
                    r_x <= r_y;
                    r_y <= r_rem;
                end
                default: r_y <= r_y;
            endcase
        end
    end

    // Output register: fill on the finishing step, drop on a taken beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_exec && w_fin) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_exec && w_uw.op == OP_FIN_DIV) begin
            r_out.multiple     <= MULTIPLE_W'(r_dvd);
            r_out.zero_divisor <= 1'b0;
        end else if (w_exec && w_uw.op == OP_FIN_ZERO) begin
            r_out.multiple     <= '0;
            r_out.zero_divisor <= 1'b1;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_data  = r_out;

    // Checks
    `LCM3_ASSERT_NXT(a_accept_starts, i_clk, i_rst_n, w_accept, r_state == ST_RUN && r_pc == '0)
    `LCM3_ASSERT_IMP(a_units_exclusive, i_clk, i_rst_n, w_mul_busy, !w_div_busy)
    `LCM3_ASSERT_IMP(a_pc_in_range, i_clk, i_rst_n, r_state == ST_RUN, r_pc < UPC_W'(PROG_LEN))
    `LCM3_ASSERT_IMP(a_error_zero, i_clk, i_rst_n, r_o_valid && r_out.zero_divisor, r_out.multiple == '0)

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
    import lcm3_pkg::*;

    localparam int PERIOD_BITS = 21;
    localparam logic [20:0] MAXP = 21'h1FFFFF;
    localparam logic [63:0] PERIOD_MASK = (64'd1 << PERIOD_BITS) - 64'd1;
    localparam int RAND_N = 530;
    localparam int IDLE_PCT = 27;
    localparam int HOLD_CYCLES = 3000;
    localparam int HOLD_AT = 150;
    localparam int PAUSE_AT = 420;
    localparam int CALM_LO = 300;
    localparam int CALM_HI = 380;
    localparam int TAIL_CYCLES = 1000;
    localparam int STALL_LIMIT = 50000;

    // One planned input beat; typed rows carry their expected result
    typedef struct packed {
        logic [20:0] a;
        logic [20:0] b;
        logic [20:0] c;
        bit          typed;
        logic [62:0] mult;
        bit          zd;
    } t_period_plan;

    localparam int DIR_N = 21;
    localparam t_period_plan DIR_TAB [DIR_N] = '{
        '{21'd0,       21'd0,       21'd0,       1'b1, 63'd0,       1'b1},
        '{21'd0,       21'd0,       MAXP,        1'b1, 63'd0,       1'b1},
        '{MAXP,        21'd0,       21'd0,       1'b1, 63'd0,       1'b1},
        '{21'd0,       MAXP,        21'd0,       1'b1, 63'd0,       1'b1},
        '{21'd0,       21'd5,       21'd7,       1'b1, 63'd0,       1'b0},
        '{MAXP,        MAXP,        21'd0,       1'b1, 63'd0,       1'b0},
        '{21'd1,       21'd1,       21'd1,       1'b1, 63'd1,       1'b0},
        '{MAXP,        MAXP,        MAXP,        1'b1, 63'h1FFFFF,  1'b0},
        '{MAXP,        21'd1,       21'd1,       1'b1, 63'h1FFFFF,  1'b0},
        '{21'd1,       MAXP,        21'd1,       1'b1, 63'h1FFFFF,  1'b0},
        '{21'd1,       21'd1,       MAXP,        1'b1, 63'h1FFFFF,  1'b0},
        '{21'h100000,  21'h100000,  21'h100000,  1'b1, 63'h100000,  1'b0},
        '{21'd2,       21'd3,       21'd5,       1'b1, 63'd30,      1'b0},
        '{21'd4,       21'd6,       21'd8,       1'b1, 63'd24,      1'b0},
        '{21'd12,      21'd18,      21'd30,      1'b1, 63'd180,     1'b0},
        '{MAXP,        21'h1FFFFE,  21'h1FFFFD,  1'b0, 63'd0,       1'b0},
        '{21'h155555,  21'h0AAAAA,  MAXP,        1'b0, 63'd0,       1'b0},
        '{21'h0AAAAA,  21'h155555,  21'd0,       1'b1, 63'd0,       1'b0},
        '{21'd1346269, 21'd832040,  21'd514229,  1'b0, 63'd0,       1'b0},
        '{21'h100000,  21'd3,       21'd1,       1'b0, 63'd0,       1'b0},
        '{21'd2097143, 21'd2097143, 21'd1,       1'b0, 63'd0,       1'b0}
    };

    logic      clk;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_in_item  in_beat = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_beat;

    t_period_plan period_plan_q[$];
    t_out_item    lcm_due_q[$];
    int           send_idx = 0;
    bit           send_done = 1'b0;
    bit           calm = 1'b0;
    int           lcm_seen = 0;
    int           zd_seen = 0;
    int           mismatches = 0;
    int           quiet_cycles = 0;

    lcm_of_three_unit #(
        .PERIOD_BITS (PERIOD_BITS)
    ) u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_beat)
    );

    // 10 ns clock
    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [63:0] euclid_gcd(input logic [63:0] x, input logic [63:0] y);
        logic [63:0] r;
        while (y != 64'd0) begin
            r = x % y;
            x = y;
            y = r;
        end
        return x;
    endfunction

    // Full product over the gcd of the pairwise products; no divisor means error
    function automatic t_out_item lcm_predict(input t_in_item beat);
        logic [63:0] pa, pb, pc, full, g;
        t_out_item   res;
        pa = 64'(beat.period_a) & PERIOD_MASK;
        pb = 64'(beat.period_b) & PERIOD_MASK;
        pc = 64'(beat.period_c) & PERIOD_MASK;
        full = pa * pb * pc;
        g = euclid_gcd(64'd0, pa * pb);
        g = euclid_gcd(g, pa * pc);
        g = euclid_gcd(g, pb * pc);
        if (g == 64'd0) begin
            res.multiple = '0;
            res.zero_divisor = 1'b1;
        end else begin
            res.multiple = 63'(full / g);
            res.zero_divisor = 1'b0;
        end
        return res;
    endfunction

    // Sender: offer beats, record expectations on acceptance
    initial begin : sender
        logic         fire;
        bit           paused_dir;
        bit           paused_mid;
        t_period_plan row;
        t_in_item     beat;
        t_out_item    want;
        paused_dir = 1'b0;
        paused_mid = 1'b0;
        wait (rst_n === 1'b1);
        while (send_idx < period_plan_q.size()) begin
            @(posedge clk);
            fire = in_valid && in_ready;
            if (fire) begin
                row = period_plan_q[send_idx];
                if (row.typed) begin
                    want.multiple = row.mult;
                    want.zero_divisor = row.zd;
                end else begin
                    want = lcm_predict(in_beat);
                end
                lcm_due_q.push_back(want);
                send_idx++;
            end
            calm = (send_idx >= CALM_LO) && (send_idx < CALM_HI);
            // hold the beat until it is taken
            if (in_valid && !fire) continue;
            // drain the block at the end of the directed part and once midway
            if ((send_idx == DIR_N && !paused_dir) || (send_idx == PAUSE_AT && !paused_mid)) begin
                in_valid <= 1'b0;
                do @(posedge clk); while (lcm_due_q.size() != 0);
                if (send_idx == DIR_N) paused_dir = 1'b1;
                else paused_mid = 1'b1;
            end
            if (send_idx < period_plan_q.size() &&
                (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                row = period_plan_q[send_idx];
                beat.period_a = row.a;
                beat.period_b = row.b;
                beat.period_c = row.c;
                in_valid <= 1'b1;
                in_beat <= beat;
            end else begin
                in_valid <= 1'b0;
            end
        end
        send_done = 1'b1;
    end

    // Receiver: check each result beat against the oldest expectation
    initial begin : receiver
        int        hold_left;
        bit        held;
        t_out_item want;
        hold_left = 0;
        held = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (out_valid && out_ready) begin
                if (lcm_due_q.size() == 0) begin
                    $display("%0t: unexpected result multiple=%0d zero_divisor=%0b",
                             $time, out_beat.multiple, out_beat.zero_divisor);
                    mismatches++;
                end else begin
                    want = lcm_due_q.pop_front();
                    if (out_beat.multiple !== want.multiple) begin
                        $display("%0t: multiple expected %0d actual %0d",
                                 $time, want.multiple, out_beat.multiple);
                        mismatches++;
                    end
                    if (out_beat.zero_divisor !== want.zero_divisor) begin
                        $display("%0t: zero_divisor expected %0b actual %0b",
                                 $time, want.zero_divisor, out_beat.zero_divisor);
                        mismatches++;
                    end
                end
                lcm_seen++;
                if (out_beat.zero_divisor) zd_seen++;
                if (lcm_seen == HOLD_AT && !held) begin
                    held = 1'b1;
                    hold_left = HOLD_CYCLES;
                end
            end
            // long hold-off lets the block back up into its input
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // Watchdog: end the run when no beat moves for too long
    initial begin : watchdog
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || rst_n !== 1'b1)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    initial begin : main
        t_period_plan row;
        int           k;
        int unsigned  f;
        int unsigned  z;
        // directed table first
        for (int i = 0; i < DIR_N; i++) begin
            period_plan_q.push_back(DIR_TAB[i]);
        end
        // random mix: full range, shared factors, small, zeros, powers of two, near max
        for (int i = 0; i < RAND_N; i++) begin
            row = '0;
            k = $urandom_range(0, 99);
            if (k < 40) begin
                row.a = 21'($urandom());
                row.b = 21'($urandom());
                row.c = 21'($urandom());
            end else if (k < 60) begin
                f = $urandom_range(1, 1023);
                row.a = 21'(f * $urandom_range(1, 2047));
                row.b = 21'(f * $urandom_range(1, 2047));
                row.c = 21'(f * $urandom_range(1, 2047));
            end else if (k < 75) begin
                row.a = 21'($urandom_range(0, 64));
                row.b = 21'($urandom_range(0, 64));
                row.c = 21'($urandom_range(0, 64));
            end else if (k < 85) begin
                row.a = 21'($urandom());
                row.b = 21'($urandom());
                row.c = 21'($urandom());
                z = $urandom_range(0, 5);
                case (z)
                    0: row.a = '0;
                    1: row.b = '0;
                    2: row.c = '0;
                    3: begin
                        row.a = '0;
                        row.b = '0;
                    end
                    4: begin
                        row.a = '0;
                        row.c = '0;
                    end
                    default: begin
                        row.b = '0;
                        row.c = '0;
                    end
                endcase
            end else if (k < 95) begin
                row.a = 21'(1) << $urandom_range(0, 20);
                row.b = 21'(1) << $urandom_range(0, 20);
                row.c = 21'(1) << $urandom_range(0, 20);
            end else begin
                row.a = MAXP - 21'($urandom_range(0, 15));
                row.b = $urandom_range(0, 1) ? MAXP : 21'($urandom());
                row.c = MAXP - 21'($urandom_range(0, 3));
            end
            period_plan_q.push_back(row);
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        wait (send_done);
        do @(posedge clk); while (lcm_due_q.size() != 0);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("sent %0d period triples (%0d directed), checked %0d results",
                 send_idx, DIR_N, lcm_seen);
        $display("%0d results flagged a zero divisor, %0d field mismatches",
                 zd_seen, mismatches);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
